FILE: rtl/rcrc_pkg.sv
// Shared types and constants for the reed cadence revolution counter.
`timescale 1ns / 1ps
`default_nettype none
package rcrc_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int CFG_W          = 16;
    localparam int DB_W           = 8;
    localparam int PER_W          = 16;
    localparam int LOOKBACK       = 4;
    localparam int MIN_FILL       = 5;
    localparam int SUM_W          = TIME_W + 2;
    localparam int CNT_N_W        = 3;
    localparam int RD_CNT_W       = 3;
    localparam int DIV_CNT_W      = $clog2(SUM_W);

    localparam logic [DB_W-1:0]  EDGE_DB_RST = 8'd4;
    localparam logic [PER_W-1:0] MIN_PER_RST = 16'd100;

    typedef enum logic [0:0] {
        REG_EDGE_DEBOUNCE  = 1'b0,
        REG_MIN_REV_PERIOD = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_DIV,
        ST_CMP,
        ST_PUSH,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/reed_cadence_rev_counter.sv
// Top level of the reed cadence revolution counter with its sequencer and ring.
//
//  Channel | Direction | Ports
//  --------+-----------+-------------------------------------------------------------
//  input   | in        | s_valid, s_ready, s_time_ms, s_switch_closed
//  result  | out       | m_valid, m_ready, m_edge_accepted, m_rev_counted, m_backfilled,
//          |           | m_backfill_time_ms, m_last_rev_time_ms, m_rev_total
//  config  | in        | cfg_wr_en, cfg_index, cfg_wdata
//
// After acceptance a result passes the EVAL and DONE states, with PUSH between them
// when a revolution counts without the period check. With the check, memory reads fetch
// the last five ring entries, then a bit-serial divider yields one quotient bit per cycle
// for the 34-bit sum; the divider is skipped when no rising period is found.
// Reset clears all control state; the ring contents stay undefined until written.
// A new transaction is accepted once the previous one has reached the output register.
`timescale 1ns / 1ps
`default_nettype none
module reed_cadence_rev_counter #(
    parameter int RING_DEPTH = rcrc_pkg::RING_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [rcrc_pkg::TIME_W-1:0] s_time_ms,
    input  wire logic                        s_switch_closed,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_edge_accepted,
    output logic                             m_rev_counted,
    output logic                             m_backfilled,
    output logic [rcrc_pkg::TIME_W-1:0]      m_backfill_time_ms,
    output logic [rcrc_pkg::TIME_W-1:0]      m_last_rev_time_ms,
    output logic [rcrc_pkg::TIME_W-1:0]      m_rev_total,
    input  wire logic                        cfg_wr_en,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [rcrc_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int TW     = rcrc_pkg::TIME_W;
    localparam int SW     = rcrc_pkg::SUM_W;

    localparam logic [HEAD_W-1:0]            HEAD_LAST = HEAD_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0]            FILL_MAX  = FILL_W'(RING_DEPTH);
    localparam logic [FILL_W-1:0]            FILL_MIN  = FILL_W'(rcrc_pkg::MIN_FILL);
    localparam logic [rcrc_pkg::RD_CNT_W-1:0] RD_LAST  =
        rcrc_pkg::RD_CNT_W'(rcrc_pkg::LOOKBACK + 1);
    localparam logic [rcrc_pkg::DIV_CNT_W-1:0] DIV_LAST = rcrc_pkg::DIV_CNT_W'(SW - 1);

    rcrc_pkg::state_t state_reg, state_next;

    logic [rcrc_pkg::DB_W-1:0]       edge_db_reg;
    logic [rcrc_pkg::PER_W-1:0]      min_per_reg;

    logic [TW-1:0]                   now_reg, now_next;
    logic                            closed_reg, closed_next;
    logic [TW-1:0]                   last_close_reg, last_close_next;
    logic [TW-1:0]                   last_open_reg, last_open_next;
    logic [TW-1:0]                   last_rev_reg, last_rev_next;
    logic                            armed_reg, armed_next;
    logic [TW-1:0]                   rev_count_reg, rev_count_next;
    logic [HEAD_W-1:0]               head_reg, head_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;

    logic [HEAD_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [rcrc_pkg::RD_CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [TW-1:0]                   newer_reg, newer_next;
    logic [SW-1:0]                   sum_reg, sum_next;
    logic [rcrc_pkg::CNT_N_W-1:0]    n_reg, n_next;
    logic [rcrc_pkg::CNT_N_W-1:0]    rem_reg, rem_next;
    logic [rcrc_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    logic                            acc_reg, acc_next;
    logic                            cnt_reg, cnt_next;
    logic                            bf_reg, bf_next;
    logic [TW-1:0]                   bf_time_reg, bf_time_next;

    logic                            m_valid_reg, m_valid_next;
    logic                            m_acc_reg, m_cnt_reg, m_bf_reg;
    logic [TW-1:0]                   m_bf_time_reg, m_last_rev_reg, m_total_reg;
    logic                            m_load;

    logic [TW-1:0]                   ring_mem [RING_DEPTH];
    logic [TW-1:0]                   rd_data_reg;
    logic                            wr_en;
    logic [TW-1:0]                   wr_data;

    logic [TW-1:0]                   close_gap, open_gap, rev_gap, diff;
    logic [rcrc_pkg::CNT_N_W:0]      trial;
    logic [TW-1:0]                   avg;
    logic [TW:0]                     lo_thr;
    logic [TW+1:0]                   hi_thr;

    function automatic logic [HEAD_W-1:0] ptr_dec(input logic [HEAD_W-1:0] p);
        ptr_dec = (p == '0) ? HEAD_LAST : p - HEAD_W'(1);
    endfunction

    function automatic logic [HEAD_W-1:0] ptr_inc(input logic [HEAD_W-1:0] p);
        ptr_inc = (p == HEAD_LAST) ? '0 : p + HEAD_W'(1);
    endfunction

    assign s_ready            = (state_reg == rcrc_pkg::ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_edge_accepted    = m_acc_reg;
    assign m_rev_counted      = m_cnt_reg;
    assign m_backfilled       = m_bf_reg;
    assign m_backfill_time_ms = m_bf_time_reg;
    assign m_last_rev_time_ms = m_last_rev_reg;
    assign m_rev_total        = m_total_reg;

    assign close_gap = now_reg - last_close_reg;
    assign open_gap  = now_reg - last_open_reg;
    assign rev_gap   = now_reg - last_rev_reg;
    assign diff      = newer_reg - rd_data_reg;
    assign trial     = {rem_reg, sum_reg[SW-1]};
    assign avg       = sum_reg[TW-1:0];
    assign lo_thr    = {1'b0, avg} + {2'b0, avg[TW-1:1]};
    assign hi_thr    = {avg, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_db_reg <= rcrc_pkg::EDGE_DB_RST;
            min_per_reg <= rcrc_pkg::MIN_PER_RST;
        end else if (cfg_wr_en) begin
            case (rcrc_pkg::cfg_idx_t'(cfg_index))
                rcrc_pkg::REG_EDGE_DEBOUNCE:  edge_db_reg <= cfg_wdata[rcrc_pkg::DB_W-1:0];
                rcrc_pkg::REG_MIN_REV_PERIOD: min_per_reg <= cfg_wdata[rcrc_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[head_reg] <= wr_data;
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rcrc_pkg::ST_IDLE;
            last_close_reg <= '0;
            last_open_reg  <= '0;
            last_rev_reg   <= '0;
            armed_reg      <= 1'b1;
            rev_count_reg  <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_close_reg <= last_close_next;
            last_open_reg  <= last_open_next;
            last_rev_reg   <= last_rev_next;
            armed_reg      <= armed_next;
            rev_count_reg  <= rev_count_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        closed_reg  <= closed_next;
        rd_ptr_reg  <= rd_ptr_next;
        rd_cnt_reg  <= rd_cnt_next;
        newer_reg   <= newer_next;
        sum_reg     <= sum_next;
        n_reg       <= n_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        bf_reg      <= bf_next;
        bf_time_reg <= bf_time_next;
        if (m_load) begin
            m_acc_reg      <= acc_reg;
            m_cnt_reg      <= cnt_reg;
            m_bf_reg       <= bf_reg;
            m_bf_time_reg  <= bf_time_reg;
            m_last_rev_reg <= last_rev_reg;
            m_total_reg    <= rev_count_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        closed_next     = closed_reg;
        last_close_next = last_close_reg;
        last_open_next  = last_open_reg;
        last_rev_next   = last_rev_reg;
        armed_next      = armed_reg;
        rev_count_next  = rev_count_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_cnt_next     = rd_cnt_reg;
        newer_next      = newer_reg;
        sum_next        = sum_reg;
        n_next          = n_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        bf_next         = bf_reg;
        bf_time_next    = bf_time_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_load          = 1'b0;
        wr_en           = 1'b0;
        wr_data         = now_reg;

        case (state_reg)
            rcrc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    now_next     = s_time_ms;
                    closed_next  = s_switch_closed;
                    acc_next     = 1'b0;
                    cnt_next     = 1'b0;
                    bf_next      = 1'b0;
                    bf_time_next = '0;
                    state_next   = rcrc_pkg::ST_EVAL;
                end
            end
            rcrc_pkg::ST_EVAL: begin
                state_next = rcrc_pkg::ST_DONE;
                if (!closed_reg) begin
                    if (open_gap >= TW'(edge_db_reg)) begin
                        acc_next       = 1'b1;
                        last_open_next = now_reg;
                        armed_next     = 1'b1;
                    end
                end else if (close_gap >= TW'(edge_db_reg)) begin
                    acc_next        = 1'b1;
                    last_close_next = now_reg;
                    if (armed_reg) begin
                        armed_next = 1'b0;
                        if (last_rev_reg == '0 || rev_gap >= TW'(min_per_reg)) begin
                            if (last_rev_reg != '0 && fill_reg >= FILL_MIN) begin
                                rd_ptr_next = ptr_dec(head_reg);
                                rd_cnt_next = '0;
                                sum_next    = '0;
                                n_next      = '0;
                                state_next  = rcrc_pkg::ST_READ;
                            end else begin
                                state_next = rcrc_pkg::ST_PUSH;
                            end
                        end
                    end
                end
            end
            rcrc_pkg::ST_READ: begin
                rd_ptr_next = ptr_dec(rd_ptr_reg);
                rd_cnt_next = rd_cnt_reg + rcrc_pkg::RD_CNT_W'(1);
                if (rd_cnt_reg != '0) begin
                    newer_next = rd_data_reg;
                end
                if (rd_cnt_reg >= rcrc_pkg::RD_CNT_W'(2) && newer_reg > rd_data_reg) begin
                    sum_next = sum_reg + SW'(diff);
                    n_next   = n_reg + rcrc_pkg::CNT_N_W'(1);
                end
                if (rd_cnt_reg == RD_LAST) begin
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = rcrc_pkg::ST_DIV;
                end
            end
            rcrc_pkg::ST_DIV: begin
                if (n_reg == '0) begin
                    state_next = rcrc_pkg::ST_PUSH;
                end else begin
                    if (trial >= {1'b0, n_reg}) begin
                        rem_next = rcrc_pkg::CNT_N_W'(trial - {1'b0, n_reg});
                        sum_next = {sum_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_next = trial[rcrc_pkg::CNT_N_W-1:0];
                        sum_next = {sum_reg[SW-2:0], 1'b0};
                    end
                    div_cnt_next = div_cnt_reg + rcrc_pkg::DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_LAST) begin
                        state_next = rcrc_pkg::ST_CMP;
                    end
                end
            end
            rcrc_pkg::ST_CMP: begin
                state_next = rcrc_pkg::ST_PUSH;
                if (avg != '0 && {1'b0, rev_gap} > lo_thr && {2'b0, rev_gap} < hi_thr) begin
                    wr_en          = 1'b1;
                    wr_data        = last_rev_reg + {1'b0, rev_gap[TW-1:1]};
                    bf_next        = 1'b1;
                    bf_time_next   = wr_data;
                    head_next      = ptr_inc(head_reg);
                    rev_count_next = rev_count_reg + TW'(1);
                    if (fill_reg != FILL_MAX) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            rcrc_pkg::ST_PUSH: begin
                wr_en          = 1'b1;
                wr_data        = now_reg;
                head_next      = ptr_inc(head_reg);
                rev_count_next = rev_count_reg + TW'(1);
                last_rev_next  = now_reg;
                cnt_next       = 1'b1;
                if (fill_reg != FILL_MAX) begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                state_next = rcrc_pkg::ST_DONE;
            end
            rcrc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rcrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rcrc_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        rev_count_reg == $past(rev_count_reg) ||
        rev_count_reg == $past(rev_count_reg) + TW'(1))
        else $error("Revolution total moved by more than one in a cycle.");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("Ring fill count exceeds the ring depth.");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= HEAD_LAST)
        else $error("Ring head points past the ring.");

    a_flag_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bf_reg |-> m_cnt_reg && m_acc_reg)
        else $error("A backfilled transaction did not count a revolution.");

endmodule
`default_nettype wire

FILE: bench/reed_cadence_rev_counter_tb.sv
// Self-checking testbench for the reed cadence revolution counter.
`timescale 1ns / 1ps
module reed_cadence_rev_counter_tb;

    localparam int RING_SLOTS    = 64;
    localparam int AVG_SPAN      = 4;
    localparam int MIN_RING_FILL = 5;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 235;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [31:0] ms;
        logic        closed;
    } reed_edge_t;

    typedef struct packed {
        logic        accepted;
        logic        counted;
        logic        backfill;
        logic [31:0] backfill_ms;
        logic [31:0] latest_rev_ms;
        logic [31:0] total;
    } rev_outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_time_ms = '0;
    logic        s_switch_closed = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_edge_accepted;
    logic        m_rev_counted;
    logic        m_backfilled;
    logic [31:0] m_backfill_time_ms;
    logic [31:0] m_last_rev_time_ms;
    logic [31:0] m_rev_total;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    reed_edge_t   edge_backlog[$];
    rev_outcome_t pending_outcomes[$];
    int unsigned  err_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_len = 0;
    int unsigned  hold_left = 0;
    bit           hold_trig = 1'b0;
    bit           hold_seen = 1'b0;
    logic [31:0]  t_cur = '0;

    // Shadow of the counter state and its two settings.
    logic [31:0] ring_mem [RING_SLOTS];
    int unsigned ring_wr = 0;
    int unsigned ring_cnt = 0;
    logic [31:0] close_ms = '0;
    logic [31:0] open_ms = '0;
    logic [31:0] rev_ms = '0;
    logic [31:0] rev_cnt = '0;
    logic        armed_sh = 1'b1;
    logic [7:0]  db_sh = 8'd4;
    logic [15:0] minper_sh = 16'd100;

    reed_cadence_rev_counter #(.RING_DEPTH(RING_SLOTS)) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_time_ms          (s_time_ms),
        .s_switch_closed    (s_switch_closed),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_edge_accepted    (m_edge_accepted),
        .m_rev_counted      (m_rev_counted),
        .m_backfilled       (m_backfilled),
        .m_backfill_time_ms (m_backfill_time_ms),
        .m_last_rev_time_ms (m_last_rev_time_ms),
        .m_rev_total        (m_rev_total),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void stash_rev(input logic [31:0] t);
        ring_mem[ring_wr] = t;
        ring_wr = (ring_wr + 1) % RING_SLOTS;
        if (ring_cnt < RING_SLOTS)
            ring_cnt++;
    endfunction

    // Mean of the rising periods among the last four; pairs that do not step forward are skipped.
    function automatic logic [31:0] recent_period_avg();
        logic [63:0] acc;
        logic [63:0] quo;
        logic [31:0] newer;
        logic [31:0] older;
        int unsigned n;
        int unsigned k;
        acc = '0;
        n = 0;
        for (k = 1; k <= AVG_SPAN; k++) begin
            newer = ring_mem[(ring_wr + RING_SLOTS - k) % RING_SLOTS];
            older = ring_mem[(ring_wr + RING_SLOTS - k - 1) % RING_SLOTS];
            if (newer > older) begin
                acc = acc + {32'd0, newer - older};
                n++;
            end
        end
        if (n == 0)
            return '0;
        quo = acc / n;
        return quo[31:0];
    endfunction

    function automatic rev_outcome_t reed_edge_outcome(input logic [31:0] now,
                                                       input logic closed);
        rev_outcome_t o;
        logic [31:0]  since;
        logic [31:0]  avg;
        logic [63:0]  lo;
        logic [63:0]  hi;
        o = '0;
        if (closed) begin
            since = now - close_ms;
            if (since >= {24'd0, db_sh}) begin
                o.accepted = 1'b1;
                close_ms = now;
                if (armed_sh) begin
                    armed_sh = 1'b0;
                    since = now - rev_ms;
                    if (rev_ms == '0 || since >= {16'd0, minper_sh}) begin
                        if (rev_ms != '0 && ring_cnt >= MIN_RING_FILL) begin
                            avg = recent_period_avg();
                            lo = ({32'd0, avg} * 64'd15) / 64'd10;
                            hi = {32'd0, avg} * 64'd4;
                            if (avg != '0 && {32'd0, since} > lo && {32'd0, since} < hi) begin
                                o.backfill_ms = rev_ms + (since >> 1);
                                o.backfill = 1'b1;
                                stash_rev(o.backfill_ms);
                                rev_cnt = rev_cnt + 1;
                            end
                        end
                        rev_ms = now;
                        rev_cnt = rev_cnt + 1;
                        stash_rev(now);
                        o.counted = 1'b1;
                    end
                end
            end
        end else begin
            since = now - open_ms;
            if (since >= {24'd0, db_sh}) begin
                o.accepted = 1'b1;
                open_ms = now;
                armed_sh = 1'b1;
            end
        end
        o.latest_rev_ms = rev_ms;
        o.total = rev_cnt;
        return o;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t ns  ERROR %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(input rcrc_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rcrc_pkg::REG_EDGE_DEBOUNCE:  db_sh = val[7:0];
            rcrc_pkg::REG_MIN_REV_PERIOD: minper_sh = val;
            default: ;
        endcase
    endtask

    task automatic queue_edge(input logic [31:0] t, input logic level);
        reed_edge_t e;
        e.ms = t;
        e.closed = level;
        edge_backlog.push_back(e);
    endtask

    // One revolution: the opening edge halfway through the gap, then the closing edge.
    task automatic queue_rev(input int unsigned gap);
        queue_edge(t_cur + gap / 2, 1'b0);
        t_cur = t_cur + gap;
        queue_edge(t_cur, 1'b1);
    endtask

    task automatic wait_drained();
        while (edge_backlog.size() != 0 || s_valid || pending_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : driver
        reed_edge_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                pending_outcomes.push_back(reed_edge_outcome(s_time_ms, s_switch_closed));
            if (!s_valid || s_ready) begin
                if (edge_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = edge_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_time_ms <= nxt.ms;
                    s_switch_closed <= nxt.closed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : hold_counter
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= hold_len;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        rev_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    flag_error("result transaction with no edge outstanding");
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_edge_accepted !== want.accepted)
                        flag_error($sformatf("edge_accepted %b, predicted %b",
                                             m_edge_accepted, want.accepted));
                    if (m_rev_counted !== want.counted)
                        flag_error($sformatf("rev_counted %b, predicted %b",
                                             m_rev_counted, want.counted));
                    if (m_backfilled !== want.backfill)
                        flag_error($sformatf("backfilled %b, predicted %b",
                                             m_backfilled, want.backfill));
                    if (m_backfill_time_ms !== want.backfill_ms)
                        flag_error($sformatf("backfill_time_ms %h, predicted %h",
                                             m_backfill_time_ms, want.backfill_ms));
                    if (m_last_rev_time_ms !== want.latest_rev_ms)
                        flag_error($sformatf("last_rev_time_ms %h, predicted %h",
                                             m_last_rev_time_ms, want.latest_rev_ms));
                    if (m_rev_total !== want.total)
                        flag_error($sformatf("rev_total %h, predicted %h",
                                             m_rev_total, want.total));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        int unsigned p;
        int unsigned sel;
        int unsigned revs;
        int unsigned per;
        int unsigned gap;
        int unsigned jit;
        int unsigned i;
        int unsigned n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                1: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'd0);
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'd0);
                end
                2: begin
                    // Bits above the debounce width must be dropped.
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE,
                              {8'($urandom_range(1, 255)), 8'hFF});
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'hFFFF);
                end
                3: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'($urandom_range(0, 40)));
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'($urandom_range(0, 1500)));
                end
                4: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'($urandom_range(0, 65535)));
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'($urandom_range(0, 65535)));
                end
                5: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'($urandom_range(0, 20)));
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'($urandom_range(50, 500)));
                end
                6: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'd255);
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'd0);
                end
                7: begin
                    write_reg(rcrc_pkg::REG_EDGE_DEBOUNCE, 16'd4);
                    write_reg(rcrc_pkg::REG_MIN_REV_PERIOD, 16'd100);
                end
                default: ;
            endcase
            case (p % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 52; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 52; end
                default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
            endcase
            if (p == 0) begin
                // Edges too close to the zero reset times are rejected.
                queue_edge(32'd2, 1'b1);
                queue_edge(32'd1, 1'b0);
                // First revolution, a bounce, and a closing edge while disarmed.
                queue_edge(32'hFFFF_FF00, 1'b1);
                queue_edge(32'hFFFF_FF02, 1'b1);
                queue_edge(32'hFFFF_FF10, 1'b1);
                queue_edge(32'hFFFF_FF80, 1'b0);
                queue_edge(32'hFFFF_FF82, 1'b0);
                // A revolution at time zero reads later as no revolution yet.
                queue_edge(32'h0000_0000, 1'b1);
                queue_edge(32'h0000_0020, 1'b0);
                queue_edge(32'h0000_0030, 1'b1);
                // Armed closing edge that comes too soon.
                queue_edge(32'h0000_0040, 1'b0);
                queue_edge(32'h0000_0050, 1'b1);
                queue_edge(32'hFFFF_FFFF, 1'b0);
                // Steady cadence, one missed revolution, then a gap of exactly four periods.
                t_cur = 32'h0000_0030;
                repeat (4) queue_rev(200);
                queue_rev(400);
                queue_rev(800);
            end
            while (edge_backlog.size() < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    revs = $urandom_range(3, 20);
                    if ($urandom_range(0, 9) == 0)
                        per = $urandom_range(1, minper_sh + 1);
                    else
                        per = ((minper_sh > 2 * db_sh + 8) ? minper_sh : 2 * db_sh + 8)
                              + $urandom_range(0, 600);
                    for (i = 0; i < revs; i++) begin
                        jit = per / 16;
                        gap = per - jit + $urandom_range(0, 2 * jit);
                        if ($urandom_range(0, 99) < 15)
                            gap = gap + per * $urandom_range(1, 3);
                        queue_rev(gap);
                        if ($urandom_range(0, 9) == 0)
                            queue_edge(t_cur + $urandom_range(0, db_sh + 2),
                                       1'($urandom_range(0, 1)));
                    end
                end else if (sel < 90) begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++) begin
                        if ($urandom_range(0, 1) == 0)
                            queue_edge($urandom, 1'($urandom_range(0, 1)));
                        else
                            queue_edge(t_cur + $urandom_range(0, 2 * db_sh + 2),
                                       1'($urandom_range(0, 1)));
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0: t_cur = $urandom;
                        1: t_cur = 32'hFFFF_FFFF - $urandom_range(0, 5000);
                        default: t_cur = $urandom_range(0, 300);
                    endcase
                end
            end
            if (p % 4 == 2) begin
                hold_len <= HOLD_CYCLES;
                hold_trig <= ~hold_trig;
            end
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
        if (err_count == 0)
            $display("reed_cadence_rev_counter: match");
        else
            $display("reed_cadence_rev_counter: mismatch");
        $finish;
    end

    initial begin : watchdog
        #(64'd10_000_000);
        $display("reed_cadence_rev_counter: mismatch");
        $finish;
    end

endmodule
